// File: src/key_debounce_long_press_repeat_core_defines.svh
// ----------------------------------------------------------------------------
// Key debounce assertion macros
// Shared assertion helpers for the key debounce core checker.
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_LONG_PRESS_REPEAT_CORE_DEFINES_SVH
`define KEY_DEBOUNCE_LONG_PRESS_REPEAT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KDLPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key debounce assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KDLPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key debounce assertion failed");

`endif

// File: src/kdlpr_pkg.sv
// ----------------------------------------------------------------------------
// Key debounce package
// Widths, register indexes, reset values and shared types of the key core.
// ----------------------------------------------------------------------------
`default_nettype none

package kdlpr_pkg;

  localparam int unsigned KEY_W         = 5;   // width of the level and event fields
  localparam int unsigned CNT_W         = 8;   // press counter and register width
  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned NUM_KEYS_DEF  = 5;

  localparam logic [CNT_W-1:0] SHORT_MIN_RST   = 8'd2;
  localparam logic [CNT_W-1:0] LONG_FIRST_RST  = 8'd30;
  localparam logic [CNT_W-1:0] REPEAT_TOP_RST  = 8'd60;
  localparam logic [CNT_W-1:0] REPEAT_BASE_RST = 8'd40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_MIN   = 8'd0,
    CFG_LONG_FIRST  = 8'd1,
    CFG_REPEAT_TOP  = 8'd2,
    CFG_REPEAT_BASE = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] short_min;
    logic [CNT_W-1:0] long_first;
    logic [CNT_W-1:0] repeat_top;
    logic [CNT_W-1:0] repeat_base;
  } cfg_t;

  // Events one key raises on one scan tick.
  typedef struct packed {
    logic short_ev;
    logic long_ev;
  } key_ev_t;

endpackage

`default_nettype wire

// File: src/kdlpr_lane.sv
// ----------------------------------------------------------------------------
// Key debounce lane
// Press counter and arm flag of one key, updated once per accepted scan tick.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlpr_lane
  import kdlpr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    tick,     // a scan transaction is accepted this cycle
  input  wire logic    pressed,
  input  wire cfg_t    cfg,
  output key_ev_t      ev        // events of the tick being accepted
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             armed_r, armed_nxt;
  logic [CNT_W-1:0] inc;

  assign inc = count_r + 1'b1;

  always_comb begin
    count_nxt   = count_r;
    armed_nxt   = armed_r;
    ev.short_ev = 1'b0;
    ev.long_ev  = 1'b0;
    if (pressed) begin
      count_nxt = inc;
      if (inc >= cfg.short_min && inc < cfg.long_first) begin
        armed_nxt = 1'b1;
      end else if (inc == cfg.long_first || inc == cfg.repeat_top) begin
        // The arm flag is left alone here, so a release right at the first
        // long count still reports a short press.
        ev.long_ev = 1'b1;
        if (inc == cfg.repeat_top) begin
          count_nxt = cfg.repeat_base;
        end
      end else begin
        armed_nxt = 1'b0;
      end
    end else if (count_r != '0) begin
      count_nxt = '0;
      if (armed_r) begin
        ev.short_ev = 1'b1;
        armed_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      armed_r <= 1'b0;
    end else if (tick) begin
      count_r <= count_nxt;
      armed_r <= armed_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/kdlpr_merge.sv
// ----------------------------------------------------------------------------
// Key debounce merge stage
// Packs the lane events into result words and holds them in an output
// register backed by a skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlpr_merge
  import kdlpr_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_take,      // scan transaction accepted
  input  wire key_ev_t          lane_ev [NUM_KEYS],
  output logic                  skid_full,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [KEY_W-1:0]      out_short_press,
  output logic [KEY_W-1:0]      out_long_press
);

  logic [KEY_W-1:0] sp_word, lp_word;
  logic [KEY_W-1:0] out_sp_r, out_lp_r, skid_sp_r, skid_lp_r;
  logic             out_vld_r, skid_vld_r;
  logic             out_free;

  // Keys past the field width cannot report, and missing keys report nothing.
  for (genvar b = 0; b < KEY_W; b++) begin : g_pack
    if (b < NUM_KEYS) begin : g_key
      assign sp_word[b] = lane_ev[b].short_ev;
      assign lp_word[b] = lane_ev[b].long_ev;
    end else begin : g_none
      assign sp_word[b] = 1'b0;
      assign lp_word[b] = 1'b0;
    end
  end

  assign out_free = !out_vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      // The input is stalled while the skid register is occupied, so a new
      // transaction and a pending skid entry never meet here.
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= in_take;
      end
    end else if (in_take) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_vld_r) begin
        out_sp_r <= skid_sp_r;
        out_lp_r <= skid_lp_r;
      end else if (in_take) begin
        out_sp_r <= sp_word;
        out_lp_r <= lp_word;
      end
    end else if (in_take) begin
      skid_sp_r <= sp_word;
      skid_lp_r <= lp_word;
    end
  end

  assign skid_full       = skid_vld_r;
  assign out_valid       = out_vld_r;
  assign out_short_press = out_sp_r;
  assign out_long_press  = out_lp_r;

endmodule

`default_nettype wire

// File: src/key_debounce_long_press_repeat_core.sv
// ----------------------------------------------------------------------------
// Key debounce core with long press and auto-repeat
// Debounces a bank of active-low keys, one lane per key, and reports short
// presses on release and long presses with auto-repeat while held.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Payload
//  in_       input      valid / stall    key_levels[4:0]
//  out_      output     valid / stall    short_press[4:0], long_press[4:0]
//  cfg_      input      valid / ready    index[7:0], data[7:0]
//
//  One scan transaction per cycle while in_stall is low; the result of an
//  accepted one is registered in the output register behind the key lanes.
//  A skid register takes one more result while the output is stalled, and
//  in_stall rises only when that register is occupied.
//  Synchronous reset clears all counters, arm flags and valid bits and
//  loads the register defaults. Configuration writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module key_debounce_long_press_repeat_core
  import kdlpr_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [KEY_W-1:0]     in_key_levels,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [KEY_W-1:0]          out_short_press,
  output logic [KEY_W-1:0]          out_long_press,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data
);

  cfg_t    cfg_r;
  logic    skid_full;
  logic    in_take;
  key_ev_t lane_ev [NUM_KEYS];

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_full;
  assign in_take   = in_valid && !skid_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_min   <= SHORT_MIN_RST;
      cfg_r.long_first  <= LONG_FIRST_RST;
      cfg_r.repeat_top  <= REPEAT_TOP_RST;
      cfg_r.repeat_base <= REPEAT_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SHORT_MIN:   cfg_r.short_min   <= cfg_data;
        CFG_LONG_FIRST:  cfg_r.long_first  <= cfg_data;
        CFG_REPEAT_TOP:  cfg_r.repeat_top  <= cfg_data;
        CFG_REPEAT_BASE: cfg_r.repeat_base <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
    logic pressed;
    if (i < KEY_W) begin : g_in
      assign pressed = !in_key_levels[i];
    end else begin : g_out
      // No input bit for this key: it always reads as released.
      assign pressed = 1'b0;
    end

    kdlpr_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .tick    (in_take),
      .pressed (pressed),
      .cfg     (cfg_r),
      .ev      (lane_ev[i])
    );
  end

  kdlpr_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_take         (in_take),
    .lane_ev         (lane_ev),
    .skid_full       (skid_full),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_short_press (out_short_press),
    .out_long_press  (out_long_press)
  );

endmodule

`default_nettype wire

// File: src/kdlpr_checker.sv
// ----------------------------------------------------------------------------
// Key debounce checker
// Port-level properties of the key debounce core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "key_debounce_long_press_repeat_core_defines.svh"

module kdlpr_checker
  import kdlpr_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [KEY_W-1:0] out_short_press,
  input wire logic [KEY_W-1:0] out_long_press
);

  // A key is either held or released on a tick, never both.
  `KDLPR_ASSERT_SAME(a_no_dual_event, clk, rst_n, out_valid, (out_short_press & out_long_press) == '0)

  // An accepted transaction always leaves a result waiting.
  `KDLPR_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_valid && !in_stall, out_valid)

  // The input stalls only while a result is already held at the output.
  `KDLPR_ASSERT_SAME(a_stall_needs_result, clk, rst_n, in_stall, out_valid)

  `KDLPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_short_press) && $stable(out_long_press))

endmodule

bind key_debounce_long_press_repeat_core kdlpr_checker u_kdlpr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_short_press (out_short_press),
  .out_long_press  (out_long_press)
);

`default_nettype wire
